/* rtl/core/lcmu_pkg.sv */
package lcmu_pkg;

  // Default operand width; results are twice as wide.
  localparam int OPERAND_WIDTH_DEF = 16;

  // Width of the microcode step counter (eight program steps).
  localparam int STEP_W = 3;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_OUT
  } op_t;

  // Jump conditions. If the condition holds, the sequencer goes to the
  // target step. Otherwise it goes to the following step.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_BAD,
    C_XY_NE,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic xy_ne;
    logic div_more;
    logic out_busy;
  } stat_t;

  // Named program steps.
  localparam logic [STEP_W-1:0] S_LOAD  = 3'd0;
  localparam logic [STEP_W-1:0] S_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] S_GCD   = 3'd2;
  localparam logic [STEP_W-1:0] S_DINIT = 3'd3;
  localparam logic [STEP_W-1:0] S_DIV   = 3'd4;
  localparam logic [STEP_W-1:0] S_MUL   = 3'd5;
  localparam logic [STEP_W-1:0] S_OUT   = 3'd6;
  localparam logic [STEP_W-1:0] S_WRAP  = 3'd7;

  // Microcode program: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      S_LOAD:  w = '{op: OP_LOAD,     cond: C_NO_IN,    target: S_LOAD};
      S_CHECK: w = '{op: OP_NOP,      cond: C_BAD,      target: S_OUT};
      S_GCD:   w = '{op: OP_GCD,      cond: C_XY_NE,    target: S_GCD};
      S_DINIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,     target: S_LOAD};
      S_DIV:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV};
      S_MUL:   w = '{op: OP_MUL,      cond: C_NEXT,     target: S_LOAD};
      S_OUT:   w = '{op: OP_OUT,      cond: C_OUT_BUSY, target: S_OUT};
      S_WRAP:  w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_LOAD};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/lcmu_seq.sv */
module lcmu_seq
  import lcmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  // Look up the control word for the current step.
  assign ctrl = ucode(step);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (ctrl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat.in_valid;
      C_BAD:      take = stat.bad;
      C_XY_NE:    take = stat.xy_ne;
      C_DIV_MORE: take = stat.div_more;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_LOAD;
    end else begin
      step <= step_next;
    end
  end

  // An accepted transaction always moves on to the operand check.
  a_load_advance: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_LOAD && stat.in_valid) |=> (step == S_CHECK))
    else $error("sequencer did not advance after a load");

endmodule

/* rtl/core/lcmu_dp.sv */
module lcmu_dp
  import lcmu_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  output stat_t                      stat,
  input  logic                       in_valid,
  input  logic [OPERAND_WIDTH-1:0]   operand_a,
  input  logic [OPERAND_WIDTH-1:0]   operand_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*OPERAND_WIDTH-1:0] multiple,
  output logic                       invalid
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(OPERAND_WIDTH);

  logic [W-1:0]  a_reg;
  logic [W-1:0]  b_reg;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [KW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [KW-1:0] cnt;
  logic [MW-1:0] prod;
  logic          bad;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // Status for the sequencer.
  assign stat.in_valid = in_valid;
  assign stat.bad      = bad;
  assign stat.xy_ne    = (x != y);
  assign stat.div_more = (cnt != KW'(W - 1));
  assign stat.out_busy = out_valid && !out_ready;

  // One restoring division step: shift in the next dividend bit and try g.
  assign rem_sh = {rem, q[W-1]};
  assign diff   = rem_sh - {1'b0, g};

  // Working registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          a_reg <= operand_a;
          b_reg <= operand_b;
          x     <= operand_a;
          y     <= operand_b;
          k     <= '0;
          bad   <= (operand_a == '0) || (operand_b == '0);
        end
      end
      OP_GCD: begin
        // Binary gcd: strip common twos into k, then halve or subtract.
        if (x != y) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
      end
      OP_DIV_INIT: begin
        g   <= x << k;
        q   <= a_reg;
        rem <= '0;
        cnt <= '0;
      end
      OP_DIV_STEP: begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      OP_MUL: begin
        prod <= MW'(q) * MW'(b_reg);
      end
      default: begin
      end
    endcase
  end

  // Output register; it loads when empty or when its transaction leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_OUT && !(out_valid && !out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT && !(out_valid && !out_ready)) begin
      multiple <= bad ? '0 : prod;
      invalid  <= bad;
    end
  end

  // An invalid result always carries a zero multiple.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid) |-> (multiple == '0))
    else $error("invalid result with nonzero multiple");

  // The divisor is never zero while dividing.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |-> (g != '0))
    else $error("division by zero gcd");

  // The gcd loop only runs on nonzero operands.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_GCD) |-> (x != '0 && y != '0))
    else $error("gcd step with a zero operand");

endmodule

/* rtl/core/least_common_multiple_unit.sv */
// Channel | Signals                                   | Direction
// input   | in_valid, in_ready, operand_a, operand_b  | into the block
// output  | out_valid, out_ready, multiple, invalid   | out of the block
//
// A transaction runs the load, operand check, binary gcd loop, divisor setup,
// division, multiply and output steps. The gcd loop runs one step a cycle
// until both values match. An operand of zero skips to the output.
// The microcode sequencer handles one operand pair at a time; in_ready is
// high only at its load step. rst is synchronous and clears the step counter
// and the output valid. A stalled output holds in its register.
module least_common_multiple_unit
  import lcmu_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPERAND_WIDTH-1:0]   operand_a,
  input  logic [OPERAND_WIDTH-1:0]   operand_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*OPERAND_WIDTH-1:0] multiple,
  output logic                       invalid
);

  ctrl_t ctrl;
  stat_t stat;

  // The input transaction is taken only at the load step, never in reset.
  assign in_ready = !rst && (ctrl.op == OP_LOAD);

  lcmu_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  lcmu_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (in_valid),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .multiple  (multiple),
    .invalid   (invalid)
  );

endmodule
